@@ hw/rtl/gbfs_pkg.sv @@
package gbfs_pkg;

    localparam int COORD_W = 6;
    localparam int DIM_W = 9;
    localparam int DIST_W = 13;
    localparam int CFG_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_WRITE_CELL = 1'b0,
        OP_QUERY      = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [DIM_W-1:0] used_w;
        logic [DIM_W-1:0] used_h;
    } dims_t;

endpackage

@@ hw/rtl/gbfs_if.sv @@
interface gbfs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [gbfs_pkg::COORD_W-1:0]  cell_x;
    logic [gbfs_pkg::COORD_W-1:0]  cell_y;
    logic                          walkable;
    logic [gbfs_pkg::COORD_W-1:0]  from_x;
    logic [gbfs_pkg::COORD_W-1:0]  from_y;
    logic [gbfs_pkg::COORD_W-1:0]  to_x;
    logic [gbfs_pkg::COORD_W-1:0]  to_y;

    modport source (output valid, operation, cell_x, cell_y, walkable, from_x, from_y,
                    to_x, to_y, input ready);
    modport sink (input valid, operation, cell_x, cell_y, walkable, from_x, from_y,
                  to_x, to_y, output ready);
endinterface

interface gbfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [gbfs_pkg::COORD_W-1:0]  next_x;
    logic [gbfs_pkg::COORD_W-1:0]  next_y;
    logic                          reachable;

    modport source (output valid, next_x, next_y, reachable, input ready);
    modport sink (input valid, next_x, next_y, reachable, output ready);
endinterface

@@ hw/rtl/gbfs_ram.sv @@
module gbfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/gbfs_cfg.sv @@
module gbfs_cfg #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gbfs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gbfs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gbfs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output gbfs_pkg::dims_t                      dims
);

    logic [gbfs_pkg::CFG_W-1:0] grid_width_reg;
    logic [gbfs_pkg::CFG_W-1:0] grid_height_reg;
    logic [gbfs_pkg::DIM_W-1:0] w_ext;
    logic [gbfs_pkg::DIM_W-1:0] h_ext;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= gbfs_pkg::GRID_DIM_RESET;
            grid_height_reg <= gbfs_pkg::GRID_DIM_RESET;
        end
        else if (wr_en)
        begin
            unique case (gbfs_pkg::reg_index_t'(paddr[2]))
                gbfs_pkg::REG_GRID_WIDTH:  grid_width_reg <= pwdata[gbfs_pkg::CFG_W-1:0];
                gbfs_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[gbfs_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (gbfs_pkg::reg_index_t'(paddr[2]))
            gbfs_pkg::REG_GRID_WIDTH:  prdata = gbfs_pkg::APB_DATA_W'(grid_width_reg);
            gbfs_pkg::REG_GRID_HEIGHT: prdata = gbfs_pkg::APB_DATA_W'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign w_ext = gbfs_pkg::DIM_W'(grid_width_reg);
    assign h_ext = gbfs_pkg::DIM_W'(grid_height_reg);
    assign dims.used_w = (w_ext > gbfs_pkg::DIM_W'(MAX_WIDTH))
                         ? gbfs_pkg::DIM_W'(MAX_WIDTH) : w_ext;
    assign dims.used_h = (h_ext > gbfs_pkg::DIM_W'(MAX_HEIGHT))
                         ? gbfs_pkg::DIM_W'(MAX_HEIGHT) : h_ext;

endmodule

@@ hw/rtl/gbfs_step.sv @@
module gbfs_step #(
    parameter int XW = 6,
    parameter int YW = 6
) (
    input  logic [XW-1:0]       cx,
    input  logic [YW-1:0]       cy,
    input  gbfs_pkg::dir_t      dir,
    input  gbfs_pkg::dims_t     dims,
    output logic [XW-1:0]       nx,
    output logic [YW-1:0]       ny,
    output logic                ok
);

    logic [gbfs_pkg::DIM_W-1:0] cx9;
    logic [gbfs_pkg::DIM_W-1:0] cy9;
    logic [gbfs_pkg::DIM_W-1:0] cx_inc;
    logic [gbfs_pkg::DIM_W-1:0] cy_inc;

    assign cx9 = gbfs_pkg::DIM_W'(cx);
    assign cy9 = gbfs_pkg::DIM_W'(cy);
    assign cx_inc = cx9 + gbfs_pkg::DIM_W'(1);
    assign cy_inc = cy9 + gbfs_pkg::DIM_W'(1);

    always_comb
    begin
        nx = cx;
        ny = cy;
        ok = 1'b0;
        unique case (dir)
            gbfs_pkg::DIR_UP:
            begin
                ny = cy - YW'(1);
                ok = (cy != '0);
            end
            gbfs_pkg::DIR_RIGHT:
            begin
                nx = cx_inc[XW-1:0];
                ok = (cx_inc < dims.used_w);
            end
            gbfs_pkg::DIR_LEFT:
            begin
                nx = cx - XW'(1);
                ok = (cx != '0);
            end
            gbfs_pkg::DIR_DOWN:
            begin
                ny = cy_inc[YW-1:0];
                ok = (cy_inc < dims.used_h);
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/grid_bfs_next_step_core.sv @@
// Answers next-step queries on a 4-connected grid whose walkability map is written one
// cell per word. A cell write leaves the block idle for the next word. A query that is
// out of range or whose source equals its target goes straight to the result.
// Any other query first clears the reached marks of the distance memory, one entry
// per cell of MAX_WIDTH by MAX_HEIGHT, each rounded up to a power of two. The search
// then reads the distance of each dequeued cell and checks its four neighbors in turn,
// reading walkability and distance for each one inside the grid. The walk back from
// the target checks neighbors the same way for one a step nearer the source. These
// distance reads share the single read port of the distance memory. A finished query
// waits while an earlier result is still held on the output. After reset the block
// clears every entry of the walkability map before it takes its first word.
module grid_bfs_next_step_core #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gbfs_in_if.sink                           in_ch,
    gbfs_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gbfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gbfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gbfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int DW = gbfs_pkg::DIST_W;
    localparam int PW = gbfs_pkg::DIM_W;

    typedef enum logic [15:0] {
        S_INIT    = 16'h0001,
        S_IDLE    = 16'h0002,
        S_CLR     = 16'h0004,
        S_SEED    = 16'h0008,
        S_DEQ     = 16'h0010,
        S_CUR     = 16'h0020,
        S_CUR_W   = 16'h0040,
        S_NB      = 16'h0080,
        S_NB_W    = 16'h0100,
        S_BT      = 16'h0200,
        S_BT_W    = 16'h0400,
        S_BK      = 16'h0800,
        S_BK_NB   = 16'h1000,
        S_BK_NB_W = 16'h2000,
        S_RES     = 16'h4000,
        S_SPARE   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    gbfs_pkg::dims_t dims;

    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [AW:0]                  head_reg, head_next;
    logic [AW:0]                  tail_reg, tail_next;
    logic [AW-1:0]                c_reg, c_next;
    logic [DW-1:0]                cd_reg, cd_next;
    logic [AW-1:0]                n_reg, n_next;
    logic [1:0]                   dir_reg, dir_next;
    logic [AW-1:0]                s_reg, s_next;
    logic [AW-1:0]                t_reg, t_next;
    logic [gbfs_pkg::COORD_W-1:0] rx_reg, rx_next;
    logic [gbfs_pkg::COORD_W-1:0] ry_reg, ry_next;
    logic                         rr_reg, rr_next;
    logic                         ov_reg, ov_next;
    logic [gbfs_pkg::COORD_W-1:0] ox_reg, ox_next;
    logic [gbfs_pkg::COORD_W-1:0] oy_reg, oy_next;
    logic                         or_reg, or_next;

    logic          walk_we, walk_wdata, walk_rdata;
    logic [AW-1:0] walk_waddr, walk_raddr;
    logic          dist_we;
    logic [AW-1:0] dist_waddr, dist_raddr;
    logic [DW:0]   dist_wdata, dist_rdata;
    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          n_ok;
    logic [AW-1:0] n_addr;

    logic [PW-1:0] fx9, fy9, tx9, ty9, wx9, wy9, cx9, cy9;
    logic          accept, src_in, tgt_in, wr_in;

    gbfs_cfg #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .dims(dims)
    );

    gbfs_step #(
        .XW(XW),
        .YW(YW)
    ) u_step (
        .cx(c_reg[XW-1:0]),
        .cy(c_reg[AW-1:XW]),
        .dir(gbfs_pkg::dir_t'(dir_reg)),
        .dims(dims),
        .nx(nx),
        .ny(ny),
        .ok(n_ok)
    );

    gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_walk (
        .clk(clk), .we(walk_we), .waddr(walk_waddr), .wdata(walk_wdata),
        .raddr(walk_raddr), .rdata(walk_rdata)
    );

    gbfs_ram #(.WIDTH(DW + 1), .DEPTH(DEPTH)) u_dist (
        .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );

    gbfs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign n_addr = {ny, nx};

    assign fx9 = PW'(in_ch.from_x);
    assign fy9 = PW'(in_ch.from_y);
    assign tx9 = PW'(in_ch.to_x);
    assign ty9 = PW'(in_ch.to_y);
    assign wx9 = PW'(in_ch.cell_x);
    assign wy9 = PW'(in_ch.cell_y);
    assign cx9 = PW'(c_reg[XW-1:0]);
    assign cy9 = PW'(c_reg[AW-1:XW]);

    assign src_in = (fx9 < dims.used_w) && (fy9 < dims.used_h);
    assign tgt_in = (tx9 < dims.used_w) && (ty9 < dims.used_h);
    assign wr_in = (wx9 < PW'(MAX_WIDTH)) && (wy9 < PW'(MAX_HEIGHT));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;

    assign out_ch.valid = ov_reg;
    assign out_ch.next_x = ox_reg;
    assign out_ch.next_y = oy_reg;
    assign out_ch.reachable = or_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        c_next = c_reg;
        cd_next = cd_reg;
        n_next = n_reg;
        dir_next = dir_reg;
        s_next = s_reg;
        t_next = t_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        rr_next = rr_reg;
        ov_next = ov_reg && !out_ch.ready;
        ox_next = ox_reg;
        oy_next = oy_reg;
        or_next = or_reg;

        walk_we = 1'b0;
        walk_waddr = cnt_reg;
        walk_wdata = 1'b0;
        walk_raddr = n_addr;
        dist_we = 1'b0;
        dist_waddr = cnt_reg;
        dist_wdata = '0;
        dist_raddr = n_addr;
        q_we = 1'b0;
        q_waddr = tail_reg[AW-1:0];
        q_wdata = n_reg;
        q_raddr = head_reg[AW-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                walk_we = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.operation == gbfs_pkg::OP_WRITE_CELL)
                    begin
                        walk_we = wr_in;
                        walk_waddr = {wy9[YW-1:0], wx9[XW-1:0]};
                        walk_wdata = in_ch.walkable;
                    end
                    else
                    begin
                        s_next = {fy9[YW-1:0], fx9[XW-1:0]};
                        t_next = {ty9[YW-1:0], tx9[XW-1:0]};
                        rx_next = in_ch.from_x;
                        ry_next = in_ch.from_y;
                        rr_next = 1'b0;
                        cnt_next = '0;
                        if (!src_in || !tgt_in)
                        begin
                            state_next = S_RES;
                        end
                        else if (in_ch.from_x == in_ch.to_x && in_ch.from_y == in_ch.to_y)
                        begin
                            rr_next = 1'b1;
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_CLR;
                        end
                    end
                end
            end
            S_CLR:
            begin
                dist_we = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                dist_we = 1'b1;
                dist_waddr = s_reg;
                dist_wdata = {1'b1, DW'(0)};
                q_we = 1'b1;
                q_waddr = '0;
                q_wdata = s_reg;
                head_next = '0;
                tail_next = (AW + 1)'(1);
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_BT;
                end
                else
                begin
                    head_next = head_reg + (AW + 1)'(1);
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                c_next = q_rdata;
                dist_raddr = q_rdata;
                state_next = S_CUR_W;
            end
            S_CUR_W:
            begin
                cd_next = dist_rdata[DW-1:0];
                dir_next = gbfs_pkg::DIR_UP;
                state_next = S_NB;
            end
            S_NB:
            begin
                n_next = n_addr;
                if (n_ok)
                begin
                    state_next = S_NB_W;
                end
                else if (dir_reg == gbfs_pkg::DIR_DOWN)
                begin
                    state_next = S_DEQ;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NB_W:
            begin
                if (walk_rdata && !dist_rdata[DW])
                begin
                    dist_we = 1'b1;
                    dist_waddr = n_reg;
                    dist_wdata = {1'b1, cd_reg + DW'(1)};
                    if (tail_reg < (AW + 1)'(DEPTH))
                    begin
                        q_we = 1'b1;
                        tail_next = tail_reg + (AW + 1)'(1);
                    end
                end
                if (dir_reg == gbfs_pkg::DIR_DOWN)
                begin
                    state_next = S_DEQ;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_BT:
            begin
                dist_raddr = t_reg;
                state_next = S_BT_W;
            end
            S_BT_W:
            begin
                if (!dist_rdata[DW])
                begin
                    state_next = S_RES;
                end
                else
                begin
                    c_next = t_reg;
                    cd_next = dist_rdata[DW-1:0];
                    state_next = S_BK;
                end
            end
            S_BK:
            begin
                rx_next = cx9[gbfs_pkg::COORD_W-1:0];
                ry_next = cy9[gbfs_pkg::COORD_W-1:0];
                rr_next = 1'b1;
                dir_next = gbfs_pkg::DIR_UP;
                if (cd_reg <= DW'(1))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_BK_NB;
                end
            end
            S_BK_NB:
            begin
                n_next = n_addr;
                if (n_ok)
                begin
                    state_next = S_BK_NB_W;
                end
                else if (dir_reg == gbfs_pkg::DIR_DOWN)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_BK_NB_W:
            begin
                if (dist_rdata[DW] && dist_rdata[DW-1:0] == cd_reg - DW'(1))
                begin
                    c_next = n_reg;
                    cd_next = dist_rdata[DW-1:0];
                    state_next = S_BK;
                end
                else if (dir_reg == gbfs_pkg::DIR_DOWN)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                    state_next = S_BK_NB;
                end
            end
            S_RES:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    ox_next = rx_reg;
                    oy_next = ry_reg;
                    or_next = rr_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            dir_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            dir_reg <= dir_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        cd_reg <= cd_next;
        n_reg <= n_next;
        s_reg <= s_next;
        t_reg <= t_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        rr_reg <= rr_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        or_reg <= or_next;
    end

endmodule
